// File: design/dwsp_pkg.sv
package dwsp_pkg;

  // Default values of the top level parameters.
  localparam int TICKS_PER_SECOND_DEF  = 100;
  localparam int DELTA_RESET_LIMIT_DEF = 50000;

  // Field and state widths.
  localparam int POS_W      = 32;
  localparam int DELTA_W    = POS_W + 1;
  localparam int TGT_W      = 24;
  localparam int GAIN_W     = 32;
  localparam int ERR_W      = 26;
  localparam int SUM_W      = 48;
  localparam int ACC_W      = 32;
  localparam int DUTY_W     = 17;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Pipeline depth, front register through output register.
  localparam int NUM_STAGES = 8;

  // The integral product is limited to plus or minus two to this power.
  localparam int KI_SAT_EXP = 61;

  // Duty accumulator reset value, 0.7 in Q2.30, and full-on duty in Q.16.
  localparam logic signed [ACC_W-1:0] ACC_RESET = 32'sd751619277;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 17'd65536;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TARGET  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TARGET = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_KP      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_KI      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_KD      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_KP     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_KI     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_KD     = 4'd7;

  // Per-wheel settings as seen by one lane.
  typedef struct packed {
    logic [TGT_W-1:0]         target;
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } lane_cfg_t;

  localparam lane_cfg_t LANE_CFG_RESET = '{
    target: 24'd60000,
    kp:     32'sd3291960,
    ki:     32'sd131678,
    kd:     32'sd0
  };

  // Stage load strobes from the pipeline control.
  typedef struct packed {
    logic [NUM_STAGES-1:0] ld;
  } stage_ctl_t;

  // What one lane reports at the output register.
  typedef struct packed {
    logic [DUTY_W-1:0]       duty;
    logic signed [ERR_W-1:0] err;
  } lane_res_t;

endpackage

// File: design/dwsp_in_if.sv
interface dwsp_in_if import dwsp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] left_position;
  logic signed [POS_W-1:0] right_position;

  modport source(output valid, output left_position, output right_position, input ready);
  modport sink(input valid, input left_position, input right_position, output ready);
endinterface

// File: design/dwsp_out_if.sv
interface dwsp_out_if import dwsp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [DUTY_W-1:0]       left_duty;
  logic [DUTY_W-1:0]       right_duty;
  logic signed [ERR_W-1:0] left_speed_error;
  logic signed [ERR_W-1:0] right_speed_error;
  logic                    encoder_reset_request;

  modport source(output valid, output left_duty, output right_duty,
                 output left_speed_error, output right_speed_error,
                 output encoder_reset_request, input ready);
  modport sink(input valid, input left_duty, input right_duty,
               input left_speed_error, input right_speed_error,
               input encoder_reset_request, output ready);
endinterface

// File: design/dwsp_front.sv
module dwsp_front import dwsp_pkg::*; #(
  parameter int DELTA_RESET_LIMIT = DELTA_RESET_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ld,
  input  logic signed [POS_W-1:0]   left_position,
  input  logic signed [POS_W-1:0]   right_position,
  output logic signed [DELTA_W-1:0] left_delta,
  output logic signed [DELTA_W-1:0] right_delta,
  output logic                      flag
);

  localparam logic signed [DELTA_W-1:0] LIMIT = DELTA_W'(DELTA_RESET_LIMIT);

  logic signed [POS_W-1:0]   left_last;
  logic signed [POS_W-1:0]   right_last;
  logic signed [DELTA_W-1:0] dl;
  logic signed [DELTA_W-1:0] dr;
  logic                      trip;

  // Exact deltas since the previous tick; either one past the limit trips both wheels.
  assign dl   = {left_position[POS_W-1], left_position} - {left_last[POS_W-1], left_last};
  assign dr   = {right_position[POS_W-1], right_position} - {right_last[POS_W-1], right_last};
  assign trip = (dl > LIMIT) || (dr > LIMIT);

  // Last positions are the only wheel state here.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_last  <= '0;
      right_last <= '0;
    end else if (ld) begin
      left_last  <= trip ? '0 : left_position;
      right_last <= trip ? '0 : right_position;
    end
  end

  // Front stage register shared by both lanes.
  always_ff @(posedge clk) begin
    if (ld) begin
      left_delta  <= dl;
      right_delta <= dr;
      flag        <= trip;
    end
  end

endmodule

// File: design/dwsp_ctrl.sv
module dwsp_ctrl import dwsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  logic       flag_in,
  output logic       flag_out,
  output stage_ctl_t ctl
);

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES:0]   rdy;
  logic [NUM_STAGES-1:0] src;
  logic [NUM_STAGES-1:1] flag_sr;

  // A stage takes a new item when it is empty or its own item moves on.
  always_comb begin
    rdy[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
    src[0] = in_valid;
    for (int k = 1; k < NUM_STAGES; k++) begin
      src[k] = valid[k-1];
    end
    ctl.ld = src & rdy[NUM_STAGES-1:0];
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid[NUM_STAGES-1];
  assign flag_out  = flag_sr[NUM_STAGES-1];

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          valid[k] <= src[k];
        end
      end
    end
  end

  // The encoder reset flag rides along with its item.
  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      flag_sr[1] <= flag_in;
    end
    for (int k = 2; k < NUM_STAGES; k++) begin
      if (ctl.ld[k]) begin
        flag_sr[k] <= flag_sr[k-1];
      end
    end
  end

  // Input only stalls once every stage holds an item.
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> (&valid))
    else $error("input stalled while a pipeline stage was empty");

endmodule

// File: design/dwsp_lane.sv
module dwsp_lane import dwsp_pkg::*; #(
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  stage_ctl_t                ctl,
  input  lane_cfg_t                 cfg,
  input  logic signed [DELTA_W-1:0] delta,
  output lane_res_t                 res
);

  localparam int TPS_W   = $clog2(TICKS_PER_SECOND + 1);
  localparam int PROD_W  = DELTA_W + TPS_W + 1;
  localparam int RAW_W   = PROD_W + 1;
  localparam int EDIF_W  = ERR_W + 1;
  localparam int HALF_W  = SUM_W / 2;
  localparam int KP_W    = GAIN_W + ERR_W;
  localparam int KD_W    = GAIN_W + EDIF_W;
  localparam int PHI_W   = GAIN_W + SUM_W - HALF_W;
  localparam int PLO_W   = GAIN_W + HALF_W + 1;
  localparam int KI_W    = GAIN_W + SUM_W;
  localparam int KIS_W   = KI_SAT_EXP + 2;
  localparam int PD_W    = KD_W + 1;
  localparam int PID_W   = KIS_W + 1;
  localparam int STEP_W  = PID_W - 10;
  localparam int ACCS_W  = STEP_W + 1;

  localparam logic signed [TPS_W:0] TPS_C = $signed({1'b0, TPS_W'(TICKS_PER_SECOND)});
  localparam logic signed [KI_W-1:0] KI_LIM =
    {{(KI_W-KI_SAT_EXP-1){1'b0}}, 1'b1, {KI_SAT_EXP{1'b0}}};
  localparam logic signed [KI_W-1:0] KI_NEG = -KI_LIM;

  // Stage 1: speed error, saturated.
  logic signed [PROD_W-1:0] speed;
  logic signed [RAW_W-1:0]  raw_err;
  logic signed [ERR_W-1:0]  err_c;
  logic signed [ERR_W-1:0]  err1;

  assign speed   = delta * TPS_C;
  assign raw_err = $signed({{(RAW_W-TGT_W){1'b0}}, cfg.target}) - {speed[PROD_W-1], speed};

  always_comb begin
    if (raw_err[RAW_W-1:ERR_W-1] != {(RAW_W-ERR_W+1){raw_err[RAW_W-1]}}) begin
      err_c = raw_err[RAW_W-1] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
    end else begin
      err_c = raw_err[ERR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      err1 <= err_c;
    end
  end

  // Stage 2: error sum and error difference; these registers hold wheel state.
  logic signed [SUM_W-1:0]  sum;
  logic signed [ERR_W-1:0]  prev_err;
  logic signed [SUM_W:0]    sum_add;
  logic signed [SUM_W-1:0]  sum_c;
  logic signed [EDIF_W-1:0] ediff_c;
  logic signed [ERR_W-1:0]  err2;
  logic signed [EDIF_W-1:0] ediff2;

  assign sum_add = {sum[SUM_W-1], sum} + {{(SUM_W-ERR_W+1){err1[ERR_W-1]}}, err1};
  assign ediff_c = {err1[ERR_W-1], err1} - {prev_err[ERR_W-1], prev_err};

  always_comb begin
    if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
      sum_c = sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_c = sum_add[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      prev_err <= '0;
    end else if (ctl.ld[2]) begin
      sum      <= sum_c;
      prev_err <= err1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      err2   <= err1;
      ediff2 <= ediff_c;
    end
  end

  // Stage 3: products; the integral gain times the sum is split into two halves.
  logic signed [KP_W-1:0]  p_kp;
  logic signed [KD_W-1:0]  p_kd;
  logic signed [PHI_W-1:0] p_hi;
  logic signed [PLO_W-1:0] p_lo;
  logic signed [ERR_W-1:0] err3;

  always_ff @(posedge clk) begin
    if (ctl.ld[3]) begin
      p_kp <= cfg.kp * err2;
      p_kd <= cfg.kd * ediff2;
      p_hi <= cfg.ki * $signed(sum[SUM_W-1:HALF_W]);
      p_lo <= cfg.ki * $signed({1'b0, sum[HALF_W-1:0]});
      err3 <= err2;
    end
  end

  // Stage 4: rebuild the integral term and limit it; add the other two terms.
  logic signed [KI_W-1:0]  ki_full;
  logic signed [KIS_W-1:0] ki_sat_c;
  logic signed [PD_W-1:0]  pd_c;
  logic signed [KIS_W-1:0] ki_sat4;
  logic signed [PD_W-1:0]  pd4;
  logic signed [ERR_W-1:0] err4;

  assign ki_full = $signed({p_hi, {HALF_W{1'b0}}})
                 + {{(KI_W-PLO_W){p_lo[PLO_W-1]}}, p_lo};
  assign pd_c    = {{(PD_W-KP_W){p_kp[KP_W-1]}}, p_kp} + {p_kd[KD_W-1], p_kd};

  always_comb begin
    priority if (ki_full > KI_LIM) begin
      ki_sat_c = KI_LIM[KIS_W-1:0];
    end else if (ki_full < KI_NEG) begin
      ki_sat_c = KI_NEG[KIS_W-1:0];
    end else begin
      ki_sat_c = ki_full[KIS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[4]) begin
      ki_sat4 <= ki_sat_c;
      pd4     <= pd_c;
      err4    <= err3;
    end
  end

  // Stage 5: full PID sum, then floor division by 1024 as an arithmetic shift.
  logic signed [PID_W-1:0]  pid;
  logic signed [STEP_W-1:0] step5;
  logic signed [ERR_W-1:0]  err5;

  assign pid = {ki_sat4[KIS_W-1], ki_sat4} + {{(PID_W-PD_W){pd4[PD_W-1]}}, pd4};

  always_ff @(posedge clk) begin
    if (ctl.ld[5]) begin
      step5 <= pid[PID_W-1:10];
      err5  <= err4;
    end
  end

  // Stage 6: duty accumulator, saturated to its width.
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACCS_W-1:0] acc_add;
  logic signed [ACC_W-1:0]  acc_c;
  logic signed [ERR_W-1:0]  err6;

  assign acc_add = {{(ACCS_W-ACC_W){acc[ACC_W-1]}}, acc} + {step5[STEP_W-1], step5};

  always_comb begin
    if (acc_add[ACCS_W-1:ACC_W-1] != {(ACCS_W-ACC_W+1){acc_add[ACCS_W-1]}}) begin
      acc_c = acc_add[ACCS_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_c = acc_add[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= ACC_RESET;
    end else if (ctl.ld[6]) begin
      acc <= acc_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[6]) begin
      err6 <= err5;
    end
  end

  // Stage 7: duty from the accumulator, clamped to 0..full.
  logic [DUTY_W-1:0]       duty_c;
  logic [DUTY_W-1:0]       duty7;
  logic signed [ERR_W-1:0] err7;

  always_comb begin
    priority if (acc[ACC_W-1]) begin
      duty_c = '0;
    end else if (acc[ACC_W-2:14] > DUTY_FULL) begin
      duty_c = DUTY_FULL;
    end else begin
      duty_c = acc[ACC_W-2:14];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[7]) begin
      duty7 <= duty_c;
      err7  <= err6;
    end
  end

  assign res.duty = duty7;
  assign res.err  = err7;

  // Wheel state changes only when its stage takes an item.
  assert property (@(posedge clk) disable iff (rst)
    !ctl.ld[2] |=> ($stable(sum) && $stable(prev_err)))
    else $error("error sum or previous error changed without a transaction");

  assert property (@(posedge clk) disable iff (rst) !ctl.ld[6] |=> $stable(acc))
    else $error("duty accumulator changed without a transaction");

endmodule

// File: design/dual_wheel_speed_pid_top.sv
// Channel   Direction  Handshake      Payload
// in_ch     input      valid/ready    left_position, right_position
// out_ch    output     valid/ready    left/right_duty, left/right_speed_error,
//                                     encoder_reset_request
// cfg       input      cfg_we         cfg_index, cfg_data (write only)
//
// The eight-stage pipeline (front, error, sum, products, integral limit, PID
// sum, accumulator, output) takes one item per cycle while out_ch does not
// stall; an item passes through these stage registers in order to out_ch.
// Reset is synchronous on rst; it empties the pipeline and loads the reset
// values of the wheel state and the registers.
// A stall on out_ch fills empty stages first; in_ch.ready falls only when all
// eight stages hold an item.
module dual_wheel_speed_pid_top import dwsp_pkg::*; #(
  parameter int TICKS_PER_SECOND  = TICKS_PER_SECOND_DEF,
  parameter int DELTA_RESET_LIMIT = DELTA_RESET_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  dwsp_in_if.sink               in_ch,
  dwsp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lane_cfg_t                 left_cfg;
  lane_cfg_t                 right_cfg;
  stage_ctl_t                ctl;
  logic signed [DELTA_W-1:0] left_delta;
  logic signed [DELTA_W-1:0] right_delta;
  logic                      front_flag;
  logic                      out_flag;
  lane_res_t                 left_res;
  lane_res_t                 right_res;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_cfg  <= LANE_CFG_RESET;
      right_cfg <= LANE_CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_TARGET:  left_cfg.target  <= cfg_data[TGT_W-1:0];
        REG_RIGHT_TARGET: right_cfg.target <= cfg_data[TGT_W-1:0];
        REG_LEFT_KP:      left_cfg.kp      <= $signed(cfg_data);
        REG_LEFT_KI:      left_cfg.ki      <= $signed(cfg_data);
        REG_LEFT_KD:      left_cfg.kd      <= $signed(cfg_data);
        REG_RIGHT_KP:     right_cfg.kp     <= $signed(cfg_data);
        REG_RIGHT_KI:     right_cfg.ki     <= $signed(cfg_data);
        REG_RIGHT_KD:     right_cfg.kd     <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Pipeline control.
  dwsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .flag_in   (front_flag),
    .flag_out  (out_flag),
    .ctl       (ctl)
  );

  // Deltas for both wheels and the shared encoder reset decision.
  dwsp_front #(
    .DELTA_RESET_LIMIT (DELTA_RESET_LIMIT)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .ld             (ctl.ld[0]),
    .left_position  (in_ch.left_position),
    .right_position (in_ch.right_position),
    .left_delta     (left_delta),
    .right_delta    (right_delta),
    .flag           (front_flag)
  );

  // One controller lane per wheel.
  dwsp_lane #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_lane_left (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .cfg   (left_cfg),
    .delta (left_delta),
    .res   (left_res)
  );

  dwsp_lane #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_lane_right (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .cfg   (right_cfg),
    .delta (right_delta),
    .res   (right_res)
  );

  // Merge both lanes and the flag into one result transaction.
  assign out_ch.left_duty             = left_res.duty;
  assign out_ch.right_duty            = right_res.duty;
  assign out_ch.left_speed_error      = left_res.err;
  assign out_ch.right_speed_error     = right_res.err;
  assign out_ch.encoder_reset_request = out_flag;

endmodule
